@@ rtl/lspf_pkg.sv @@
`default_nettype none

package lspf_pkg;

	// Frame layout
	localparam int unsigned START_BYTES = 4;
	localparam int unsigned PIX_BYTES   = 4;
	localparam int unsigned END_BYTES   = 44;

	// Wide enough to count the longest run of bytes
	localparam int unsigned CNT_W = $clog2(END_BYTES);

	localparam logic [7:0] START_BYTE  = 8'h00;
	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE    = 8'hFF;

	// Classified pixel, passed from the front to the back
	typedef struct packed {
		logic [7:0] colour0;
		logic [7:0] colour1;
		logic [7:0] colour2;
		logic       first;
		logic       last;
	} pix_desc_t;

endpackage

`default_nettype wire

@@ rtl/lspf_ifs.sv @@
`default_nettype none

// Pixel channel: one packed pixel per beat
interface lspf_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       first_pixel;
	logic       last_pixel;

	modport source (output valid, pixel_byte, first_pixel, last_pixel, input ready);
	modport sink   (input valid, pixel_byte, first_pixel, last_pixel, output ready);
endinterface

// Byte channel: one stream byte per beat
interface lspf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, out_byte, run_end, input ready);
	modport sink   (input valid, out_byte, run_end, output ready);
endinterface

`default_nettype wire

@@ rtl/lspf_front.sv @@
`default_nettype none

module lspf_front
	import lspf_pkg::*;
(
	lspf_pix_if.sink   pixel_in,
	input  wire logic [7:0] scale_code,
	input  wire logic       q_ready,
	output logic            q_push,
	output pix_desc_t       q_desc
);

	// Shift by twice the exponent, then optional brightness scaling
	function automatic logic [7:0] colour_byte(input logic [1:0] field,
		input logic [1:0] expo, input logic [7:0] scale);
		logic [7:0]  shifted;
		logic [15:0] prod;
		shifted = {6'b0, field} << {expo, 1'b0};
		prod    = 16'(shifted) * 16'(scale);
		return (scale == 8'd0) ? shifted : prod[15:8];
	endfunction

	logic [1:0] expo;

	assign expo = pixel_in.pixel_byte[7:6];

	// Beat goes straight into the queue when it has room
	assign pixel_in.ready = q_ready;
	assign q_push         = pixel_in.valid & q_ready;

	always_comb begin
		q_desc.colour0 = colour_byte(pixel_in.pixel_byte[5:4], expo, scale_code);
		q_desc.colour1 = colour_byte(pixel_in.pixel_byte[3:2], expo, scale_code);
		q_desc.colour2 = colour_byte(pixel_in.pixel_byte[1:0], expo, scale_code);
		q_desc.first   = pixel_in.first_pixel;
		q_desc.last    = pixel_in.last_pixel;
	end

endmodule

`default_nettype wire

@@ rtl/lspf_queue.sv @@
`default_nettype none

module lspf_queue
	import lspf_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pix_desc_t push_desc,
	output logic           push_ready,
	input  wire logic      pop,
	output logic           pop_valid,
	output pix_desc_t      pop_desc
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

	pix_desc_t          entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W_Q'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = entry_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

@@ rtl/lspf_back.sv @@
`default_nettype none

module lspf_back
	import lspf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire pix_desc_t  q_desc,
	output logic            q_pop,
	lspf_byte_if.source     byte_out
);

	localparam logic [1:0] ST_START = 2'd0;
	localparam logic [1:0] ST_PIX   = 2'd1;
	localparam logic [1:0] ST_END   = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	pix_desc_t        cur_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_end_q;

	logic             out_can;
	logic             emit;
	logic             last_byte;
	logic             run_done;
	logic [7:0]       byte_nxt;

	assign byte_out.valid    = out_valid_q;
	assign byte_out.out_byte = out_byte_q;
	assign byte_out.run_end  = run_end_q;

	// Output register is free when empty or being drained
	assign out_can = !out_valid_q || byte_out.ready;
	assign emit    = busy_q && out_can;

	// Byte selection and end-of-run detection
	always_comb begin
		byte_nxt  = HEADER_BYTE;
		run_done  = 1'b0;
		last_byte = 1'b0;
		unique case (state_q)
			ST_START: begin
				byte_nxt = START_BYTE;
				run_done = (cnt_q == CNT_W'(START_BYTES - 1));
			end
			ST_PIX: begin
				case (cnt_q[1:0])
					2'd0:    byte_nxt = HEADER_BYTE;
					2'd1:    byte_nxt = cur_q.colour0;
					2'd2:    byte_nxt = cur_q.colour1;
					default: byte_nxt = cur_q.colour2;
				endcase
				run_done  = (cnt_q == CNT_W'(PIX_BYTES - 1));
				last_byte = run_done && !cur_q.last;
			end
			ST_END: begin
				byte_nxt  = END_BYTE;
				run_done  = (cnt_q == CNT_W'(END_BYTES - 1));
				last_byte = run_done;
			end
			default: begin
				byte_nxt = HEADER_BYTE;
			end
		endcase
	end

	// Take the next pixel when idle or on the final byte of the current one
	assign q_pop = q_valid && (!busy_q || (emit && last_byte));

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			state_q     <= ST_PIX;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_can) begin
				out_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q  <= 1'b1;
				state_q <= q_desc.first ? ST_START : ST_PIX;
				cnt_q   <= '0;
			end else if (emit) begin
				if (last_byte) begin
					busy_q <= 1'b0;
				end else if (run_done) begin
					state_q <= (state_q == ST_START) ? ST_PIX : ST_END;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (emit) begin
			out_byte_q <= byte_nxt;
			run_end_q  <= last_byte;
		end
	end

endmodule

`default_nettype wire

@@ rtl/led_strip_pixel_framer_unit.sv @@
// A pixel's first byte passes the queue entry, the back end's sequencer state and
// the output register. The back end's byte sequencer sends one output byte per
// cycle while byte_out is ready; a pixel is 4 bytes, frame start 4, frame end 44.
// A short pixel queue lets new pixels be taken while bytes are still being sent.
// Reset (arst_n low, asynchronous) empties the queue and output, scale_code to 0.
`default_nettype none

module led_strip_pixel_framer_unit
	import lspf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	lspf_pix_if.sink        pixel_in,
	lspf_byte_if.source     byte_out
);

	logic [7:0] scale_code_q;
	logic       q_ready;
	logic       q_push;
	pix_desc_t  push_desc;
	logic       q_valid;
	logic       q_pop;
	pix_desc_t  pop_desc;

	// Brightness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_code_q <= 8'd0;
		end else if (cfg_we) begin
			scale_code_q <= cfg_wdata;
		end
	end

	lspf_front u_front (
		.pixel_in   (pixel_in),
		.scale_code (scale_code_q),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_desc     (push_desc)
	);

	lspf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (push_desc),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_desc   (pop_desc)
	);

	lspf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_desc   (pop_desc),
		.q_pop    (q_pop),
		.byte_out (byte_out)
	);

endmodule

`default_nettype wire

@@ dv/lspf_stream_checker.sv @@
`default_nettype none

module lspf_stream_checker
	import lspf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	lspf_pix_if             pix_mon,
	lspf_byte_if            byte_mon,
	output int              fail_count,
	output int              pending_bytes
);

	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} stream_byte_t;

	// Bytes still owed by the block, oldest first
	stream_byte_t stream_q[$];
	logic [7:0]   scale_code = 8'h00;

	// Colour level: field shifted by twice the exponent, then optional brightness scale
	function automatic logic [7:0] colour_level(input logic [1:0] field, input logic [1:0] expo,
			input logic [7:0] scale);
		logic [15:0] lvl;
		lvl = {14'd0, field} << {expo, 1'b0};
		if (scale != 8'd0) begin
			lvl = (lvl * {8'd0, scale}) >> 8;
		end
		return lvl[7:0];
	endfunction

	task automatic queue_byte(input logic [7:0] data);
		stream_byte_t sb;
		sb.data = data;
		sb.tail = 1'b0;
		stream_q.push_back(sb);
	endtask

	// Whole byte run for one pixel: start bytes, header, colours, end bytes
	task automatic predict_pixel(input logic [7:0] px, input logic first, input logic last);
		logic [1:0] expo;
		expo = px[7:6];
		if (first) begin
			repeat (START_BYTES) queue_byte(START_BYTE);
		end
		queue_byte(HEADER_BYTE);
		queue_byte(colour_level(px[5:4], expo, scale_code));
		queue_byte(colour_level(px[3:2], expo, scale_code));
		queue_byte(colour_level(px[1:0], expo, scale_code));
		if (last) begin
			repeat (END_BYTES) queue_byte(END_BYTE);
		end
		stream_q[stream_q.size() - 1].tail = 1'b1;
	endtask

	// Watch config, compare output beats, predict input beats
	always @(posedge clk or negedge arst_n) begin
		int           errs;
		stream_byte_t want;
		if (!arst_n) begin
			scale_code = 8'h00;
			stream_q.delete();
			fail_count    <= 0;
			pending_bytes <= 0;
		end else begin
			errs = fail_count;
			if (cfg_we) begin
				scale_code = cfg_wdata;
			end
			if (byte_mon.valid && byte_mon.ready) begin
				if (stream_q.size() == 0) begin
					$display("%0t: unexpected beat, got byte %02h run_end %0b", $time,
						byte_mon.out_byte, byte_mon.run_end);
					errs++;
				end else begin
					want = stream_q.pop_front();
					if (byte_mon.out_byte !== want.data) begin
						$display("%0t: out_byte expected %02h got %02h", $time,
							want.data, byte_mon.out_byte);
						errs++;
					end
					if (byte_mon.run_end !== want.tail) begin
						$display("%0t: run_end expected %0b got %0b", $time,
							want.tail, byte_mon.run_end);
						errs++;
					end
				end
			end
			if (pix_mon.valid && pix_mon.ready) begin
				predict_pixel(pix_mon.pixel_byte, pix_mon.first_pixel, pix_mon.last_pixel);
			end
			fail_count    <= errs;
			pending_bytes <= stream_q.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_led_strip_pixel_framer_unit.sv @@
`default_nettype none

module tb_led_strip_pixel_framer_unit;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         fail_count;
	int         pending_bytes;
	bit         calm = 1'b0;
	int         stall_left = 0;
	int         quiet_left = 0;

	lspf_pix_if  pix_if();
	lspf_byte_if byte_if();

	led_strip_pixel_framer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixel_in  (pix_if),
		.byte_out  (byte_if)
	);

	lspf_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pix_mon       (pix_if),
		.byte_mon      (byte_if),
		.fail_count    (fail_count),
		.pending_bytes (pending_bytes)
	);

	always #5 clk = ~clk;

	// Output backpressure: random stall bursts, occasional quiet stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_if.ready <= 1'b0;
		end else if (calm || quiet_left > 0) begin
			if (quiet_left > 0) quiet_left--;
			byte_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			byte_if.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			byte_if.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 30) == 0) quiet_left = $urandom_range(20, 80);
			byte_if.ready <= 1'b1;
		end
	end

	// One pixel beat, with an optional gap ahead of it
	task automatic push_pixel(input logic [7:0] px, input logic first, input logic last);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.pixel_byte  <= px;
		pix_if.first_pixel <= first;
		pix_if.last_pixel  <= last;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
	endtask

	// Stop sending and wait for every owed byte
	task automatic drain;
		pix_if.valid <= 1'b0;
		do @(posedge clk); while (pending_bytes != 0);
	endtask

	task automatic set_scale(input logic [7:0] code);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly well-formed frames of random pixels, some loose marks
	task automatic run_phase(input logic [7:0] code, input int n_pixels);
		int done;
		int len;
		set_scale(code);
		push_pixel(8'hFF, 1'b1, 1'b1);
		push_pixel(8'hC1, 1'b0, 1'b0);
		done = 0;
		while (done < n_pixels) begin
			if ($urandom_range(0, 4) == 0) begin
				push_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
					$urandom_range(0, 3) == 0);
				done++;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					push_pixel(8'($urandom_range(0, 255)), i == 0, i == len - 1);
				end
				done += len;
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 8'h00;
		pix_if.valid        = 1'b0;
		pix_if.pixel_byte   = 8'h00;
		pix_if.first_pixel  = 1'b0;
		pix_if.last_pixel   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every exponent, all mark combinations
		push_pixel(8'h00, 1'b1, 1'b0);
		push_pixel(8'h3F, 1'b0, 1'b0);
		push_pixel(8'h7F, 1'b0, 1'b0);
		push_pixel(8'hBF, 1'b0, 1'b0);
		push_pixel(8'hFF, 1'b0, 1'b1);
		push_pixel(8'hFF, 1'b1, 1'b1);
		push_pixel(8'h00, 1'b1, 1'b1);
		push_pixel(8'hC0, 1'b0, 1'b0);
		push_pixel(8'hE4, 1'b0, 1'b0);
		push_pixel(8'h1B, 1'b0, 1'b0);
		push_pixel(8'h55, 1'b0, 1'b0);
		push_pixel(8'hAA, 1'b0, 1'b0);
		push_pixel(8'h80, 1'b0, 1'b1);
		push_pixel(8'h40, 1'b0, 1'b0);

		// Scale settings, extremes included; last phase runs without idling
		run_phase(8'hFF, 38);
		run_phase(8'h01, 38);
		run_phase(8'h80, 38);
		run_phase(8'($urandom_range(2, 254)), 38);
		calm = 1'b1;
		run_phase(8'h00, 38);

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_led_strip_pixel_framer_unit: clean");
		end else begin
			$display("tb_led_strip_pixel_framer_unit: errors");
		end
		$finish;
	end

	// Hard stop
	initial begin
		#20000000;
		$display("tb_led_strip_pixel_framer_unit: errors");
		$finish;
	end

endmodule

`default_nettype wire
